[hdl/ffha_pkg.sv]
// Shared types and constants for the first-fit heap allocator.
// Used by the controller, the datapath, the top level and the checker.
package ffha_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_BLOCK_BYTES  = 64;
    localparam int DEF_HEADER_BYTES = 24;
    localparam int DEF_OFFSET_BITS  = 24;

    localparam int FIELD_W  = 24;
    localparam int NEED_W   = FIELD_W + 2;
    localparam int COUNT_W  = 7;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 40;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic [FIELD_W-1:0] HEAP_RESET = 24'hFFFFFF;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_INIT  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_BAD_OFS = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_RD_IDX,
        OP_NEXT_IDX,
        OP_TAKE_CUR,
        OP_RD_P_M1,
        OP_WR_P_UP,
        OP_RD_P_P1,
        OP_WR_P_DN,
        OP_N_DEC,
        OP_WR_SPLIT,
        OP_WR_ALLOC,
        OP_RD_NEXT,
        OP_RD_PREV,
        OP_MERGE_NEXT,
        OP_WR_PREV,
        OP_WR_FREE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic    idle;
        dp_op_t  op;
        status_t st;
    } cmd_t;

    typedef struct packed {
        logic    fire;
        action_t act;
        logic    end_scan;
        logic    fit;
        logic    split;
        logic    full;
        logic    match;
        logic    hdr_bad;
        logic    next_exists;
        logic    prev_exists;
        logic    rd_used;
        logic    su_done;
        logic    sd_done;
    } sts_t;

endpackage

[hdl/ffha_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/ffha_ctrl.sv]
// Controller state machine of the heap allocator.
// Depends on ffha_pkg; drives commands to ffha_datapath and reads its status.
module ffha_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  ffha_pkg::sts_t sts,
    output ffha_pkg::cmd_t cmd
);
    import ffha_pkg::*;

    typedef enum logic [20:0] {
        S_BOOT   = 21'd1 << 0,
        S_IDLE   = 21'd1 << 1,
        S_DISP   = 21'd1 << 2,
        S_INIT   = 21'd1 << 3,
        S_A_RD   = 21'd1 << 4,
        S_A_CHK  = 21'd1 << 5,
        S_SU_RD  = 21'd1 << 6,
        S_SU_WR  = 21'd1 << 7,
        S_A_WS   = 21'd1 << 8,
        S_A_WA   = 21'd1 << 9,
        S_F_RD   = 21'd1 << 10,
        S_F_CHK  = 21'd1 << 11,
        S_FN_RD  = 21'd1 << 12,
        S_FN_CHK = 21'd1 << 13,
        S_FP_RD  = 21'd1 << 14,
        S_FP_CHK = 21'd1 << 15,
        S_F_WF   = 21'd1 << 16,
        S_SD_RD  = 21'd1 << 17,
        S_SD_WR  = 21'd1 << 18,
        S_SD_END = 21'd1 << 19,
        S_FIN_OK = 21'd1 << 20
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            ret_reg   <= S_FIN_OK;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.idle   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.st     = ST_OK;
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.fire)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.act)
                    ACT_ALLOC: state_next = S_A_RD;
                    ACT_FREE:
                    begin
                        if (sts.hdr_bad)
                        begin
                            cmd.op     = OP_FINISH;
                            cmd.st     = ST_BAD_OFS;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                    ACT_INIT: state_next = S_INIT;
                    default:
                    begin
                        cmd.op     = OP_FINISH;
                        cmd.st     = ST_BAD_OFS;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_FIN_OK;
            end
            S_A_RD:
            begin
                if (sts.end_scan)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.st     = ST_NO_FIT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                if (!sts.fit)
                begin
                    cmd.op     = OP_NEXT_IDX;
                    state_next = S_A_RD;
                end
                else if (sts.split && sts.full)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.st     = ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_TAKE_CUR;
                    state_next = sts.split ? S_SU_RD : S_A_WA;
                end
            end
            S_SU_RD:
            begin
                if (sts.su_done)
                begin
                    state_next = S_A_WS;
                end
                else
                begin
                    cmd.op     = OP_RD_P_M1;
                    state_next = S_SU_WR;
                end
            end
            S_SU_WR:
            begin
                cmd.op     = OP_WR_P_UP;
                state_next = S_SU_RD;
            end
            S_A_WS:
            begin
                cmd.op     = OP_WR_SPLIT;
                state_next = S_A_WA;
            end
            S_A_WA:
            begin
                cmd.op     = OP_WR_ALLOC;
                state_next = S_FIN_OK;
            end
            S_F_RD:
            begin
                if (sts.end_scan)
                begin
                    cmd.op     = OP_FINISH;
                    cmd.st     = ST_BAD_OFS;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (sts.match)
                begin
                    cmd.op     = OP_TAKE_CUR;
                    state_next = S_FN_RD;
                end
                else
                begin
                    cmd.op     = OP_NEXT_IDX;
                    state_next = S_F_RD;
                end
            end
            S_FN_RD:
            begin
                if (sts.next_exists)
                begin
                    cmd.op     = OP_RD_NEXT;
                    state_next = S_FN_CHK;
                end
                else
                begin
                    state_next = S_FP_RD;
                end
            end
            S_FN_CHK:
            begin
                if (!sts.rd_used)
                begin
                    cmd.op     = OP_MERGE_NEXT;
                    ret_next   = S_FP_RD;
                    state_next = S_SD_RD;
                end
                else
                begin
                    state_next = S_FP_RD;
                end
            end
            S_FP_RD:
            begin
                if (sts.prev_exists)
                begin
                    cmd.op     = OP_RD_PREV;
                    state_next = S_FP_CHK;
                end
                else
                begin
                    state_next = S_F_WF;
                end
            end
            S_FP_CHK:
            begin
                if (!sts.rd_used)
                begin
                    cmd.op     = OP_WR_PREV;
                    ret_next   = S_FIN_OK;
                    state_next = S_SD_RD;
                end
                else
                begin
                    state_next = S_F_WF;
                end
            end
            S_F_WF:
            begin
                cmd.op     = OP_WR_FREE;
                state_next = S_FIN_OK;
            end
            S_SD_RD:
            begin
                if (sts.sd_done)
                begin
                    state_next = S_SD_END;
                end
                else
                begin
                    cmd.op     = OP_RD_P_P1;
                    state_next = S_SD_WR;
                end
            end
            S_SD_WR:
            begin
                cmd.op     = OP_WR_P_DN;
                state_next = S_SD_RD;
            end
            S_SD_END:
            begin
                cmd.op     = OP_N_DEC;
                state_next = ret_reg;
            end
            S_FIN_OK:
            begin
                cmd.op     = OP_FINISH;
                cmd.st     = ST_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

[hdl/ffha_datapath.sv]
// Datapath of the heap allocator: segment table memory, pointers, size rounding,
// result register and stream handshakes. Depends on ffha_pkg and ffha_ram.
// BLOCK_BYTES must be a power of two (unchecked); request sizes round up by mask.
module ffha_datapath #(
    parameter int MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
    parameter int BLOCK_BYTES  = ffha_pkg::DEF_BLOCK_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int OFFSET_BITS  = ffha_pkg::DEF_OFFSET_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffha_pkg::cmd_t                cmd,
    output ffha_pkg::sts_t                sts,
    input  logic                          cfg_wr_en,
    input  logic [ffha_pkg::FIELD_W-1:0]  cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ffha_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ffha_pkg::OUT_W-1:0]    m_tdata
);
    import ffha_pkg::*;

    localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int IW  = AW + 1;
    localparam int OB  = OFFSET_BITS;
    localparam int EW  = 2 * OB + 1;
    localparam int CW  = (OB > FIELD_W) ? OB : FIELD_W;
    localparam int MW  = (OB > NEED_W) ? OB : NEED_W;

    logic [FIELD_W-1:0] heap_reg;
    logic [IW-1:0]      n_reg, idx_reg, p_reg;
    logic [COUNT_W-1:0] count_reg;
    action_t            act_reg;
    logic [FIELD_W-1:0] addr_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [OB-1:0]      cur_start_reg, cur_len_reg;
    logic               split_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [EW-1:0]      ram_wdata, ram_rdata;
    logic [OB-1:0]      rd_start, rd_len;
    logic               rd_used;
    logic [IW-1:0]      idx_p1, idx_m1, p_p1, p_m1;
    logic [NEED_W-1:0]  sum_in, need_in;
    logic [MW-1:0]      len_m, need_m, diff_m;
    logic [FIELD_W-1:0] hdr;
    logic [CW-1:0]      addr_sum;
    logic [COUNT_W-1:0] count_new;
    logic [OB-1:0]      need_ob;

    ffha_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_SEGMENTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_start  = ram_rdata[OB-1:0];
    assign rd_len    = ram_rdata[2*OB-1:OB];
    assign rd_used   = ram_rdata[2*OB];
    assign idx_p1    = idx_reg + IW'(1);
    assign idx_m1    = idx_reg - IW'(1);
    assign p_p1      = p_reg + IW'(1);
    assign p_m1      = p_reg - IW'(1);
    assign sum_in    = NEED_W'(s_tdata[25:2]) + NEED_W'(HEADER_BYTES);
    assign need_in   = (sum_in + NEED_W'(BLOCK_BYTES - 1)) & ~NEED_W'(BLOCK_BYTES - 1);
    assign len_m     = MW'(rd_len);
    assign need_m    = MW'(need_reg);
    assign diff_m    = len_m - need_m;
    assign hdr       = addr_reg - FIELD_W'(HEADER_BYTES);
    assign addr_sum  = CW'(cur_start_reg + OB'(HEADER_BYTES));
    assign need_ob   = OB'(need_reg);

    assign s_tready = cmd.idle && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        sts.fire        = cmd.idle && s_tvalid && s_tready;
        sts.act         = act_reg;
        sts.end_scan    = idx_reg == n_reg;
        sts.fit         = !rd_used && (len_m >= need_m);
        sts.split       = diff_m > MW'(HEADER_BYTES);
        sts.full        = n_reg == IW'(MAX_SEGMENTS);
        sts.match       = rd_used && (CW'(rd_start) == CW'(hdr));
        sts.hdr_bad     = addr_reg < FIELD_W'(HEADER_BYTES);
        sts.next_exists = idx_p1 < n_reg;
        sts.prev_exists = idx_reg != '0;
        sts.rd_used     = rd_used;
        sts.su_done     = p_reg == idx_p1;
        sts.sd_done     = p_p1 >= n_reg;
    end

    always_comb
    begin
        count_new = count_reg;
        if (cmd.st == ST_OK)
        begin
            if (act_reg == ACT_ALLOC && count_reg != COUNT_MAX)
            begin
                count_new = count_reg + COUNT_W'(1);
            end
            else if (act_reg == ACT_FREE && count_reg != '0)
            begin
                count_new = count_reg - COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[AW-1:0];
        case (cmd.op)
            OP_RD_P_M1: ram_raddr = p_m1[AW-1:0];
            OP_RD_P_P1: ram_raddr = p_p1[AW-1:0];
            OP_RD_NEXT: ram_raddr = idx_p1[AW-1:0];
            OP_RD_PREV: ram_raddr = idx_m1[AW-1:0];
            OP_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {1'b0, OB'(heap_reg), OB'(0)};
            end
            OP_WR_P_UP, OP_WR_P_DN:
            begin
                ram_we    = 1'b1;
                ram_waddr = p_reg[AW-1:0];
            end
            OP_WR_SPLIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_p1[AW-1:0];
                ram_wdata = {1'b0, cur_len_reg - need_ob, cur_start_reg + need_ob};
            end
            OP_WR_ALLOC:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, split_reg ? need_ob : cur_len_reg, cur_start_reg};
            end
            OP_WR_PREV:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1[AW-1:0];
                ram_wdata = {1'b0, rd_len + cur_len_reg, rd_start};
            end
            OP_WR_FREE:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, cur_len_reg, cur_start_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg     <= HEAP_RESET;
            n_reg        <= IW'(1);
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                heap_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_INIT:
                begin
                    n_reg     <= IW'(1);
                    count_reg <= '0;
                end
                OP_N_DEC:    n_reg <= n_reg - IW'(1);
                OP_WR_SPLIT: n_reg <= n_reg + IW'(1);
                OP_FINISH:
                begin
                    count_reg    <= count_new;
                    m_tvalid_reg <= 1'b1;
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                act_reg  <= action_t'(s_tdata[1:0]);
                addr_reg <= s_tdata[49:26];
                need_reg <= need_in;
                idx_reg  <= '0;
            end
            OP_NEXT_IDX: idx_reg <= idx_p1;
            OP_TAKE_CUR:
            begin
                cur_start_reg <= rd_start;
                cur_len_reg   <= rd_len;
                split_reg     <= sts.split;
                p_reg         <= n_reg;
            end
            OP_WR_P_UP: p_reg <= p_m1;
            OP_WR_P_DN: p_reg <= p_p1;
            OP_MERGE_NEXT:
            begin
                cur_len_reg <= cur_len_reg + rd_len;
                p_reg       <= idx_p1;
            end
            OP_WR_PREV: p_reg <= idx_reg;
            OP_FINISH:
            begin
                m_tdata_reg <= {7'd0, count_new, cmd.st,
                    ((cmd.st == ST_OK) && (act_reg == ACT_ALLOC)) ? addr_sum[FIELD_W-1:0]
                                                                  : FIELD_W'(0)};
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end
endmodule

[hdl/first_fit_heap_allocator_core.sv]
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath and ffha_ram.
//
//   Channel    Direction  Transaction contents
//   s_axis     in         action, request_bytes, address
//   m_axis     out        address_out, status, live_count
//   cfg        in         heap_bytes write
//
// Allocation dispatches the request, scans segments in order, moves table entries up
// when a segment is split and then finishes.
// Free scans for the matching entry and moves table entries down for each merge,
// and both neighbors can merge.
// After reset the controller writes the initial segment before input is taken.
// Input is taken only when the controller is idle and the result register is empty
// or being read in the same cycle.
module first_fit_heap_allocator_core #(
    parameter int MAX_SEGMENTS = ffha_pkg::DEF_MAX_SEGMENTS,
    parameter int BLOCK_BYTES  = ffha_pkg::DEF_BLOCK_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int OFFSET_BITS  = ffha_pkg::DEF_OFFSET_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [ffha_pkg::FIELD_W-1:0] cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ffha_pkg::IN_W-1:0]    s_tdata,   // action, request_bytes, address
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ffha_pkg::OUT_W-1:0]   m_tdata    // address_out, status, live_count
);
    import ffha_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffha_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .sts  (sts),
        .cmd  (cmd)
    );

    ffha_datapath #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );
endmodule

[hdl/ffha_checker.sv]
// Port-level checker for the heap allocator and its bind to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_core.
module ffha_props (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ffha_pkg::OUT_W-1:0]   m_tdata
);
    import ffha_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result transaction changed while stalled.");

    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[25:24] != ST_OK) |-> m_tdata[23:0] == '0)
        else $error("Failed request returned a nonzero offset.");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:26] <= COUNT_W'(DEF_MAX_SEGMENTS))
        else $error("Live count exceeds the segment table size.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("Input taken while a result is blocked.");
endmodule

bind first_fit_heap_allocator_core ffha_props u_ffha_props (.*);

[bench/ffha_checker.sv]
// Checker for the first-fit heap allocator: predicts each result from the input stream.
// Compares results field by field and reports the failure count to the top.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_checker
    import ffha_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata,
    output int                 errors,
    output int                 pending,
    output int                 compared
);

    localparam int NSEG = DEF_MAX_SEGMENTS;
    localparam int HDR  = DEF_HEADER_BYTES;
    localparam int BLK  = DEF_BLOCK_BYTES;

    typedef struct packed {
        logic [FIELD_W-1:0] addr;
        status_t            st;
        logic [COUNT_W-1:0] live;
    } outcome_t;

    outcome_t outcome_q[$];

    logic [FIELD_W-1:0] heap_len;
    longint seg_base[NSEG];
    longint seg_len[NSEG];
    bit     seg_busy[NSEG];
    bit     seg_ok[NSEG];
    int     live_allocs;

    assign pending = outcome_q.size();

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic void clear_heap();
        for (int i = 0; i < NSEG; i++)
        begin
            seg_base[i] = 0;
            seg_len[i]  = 0;
            seg_busy[i] = 0;
            seg_ok[i]   = 0;
        end
        seg_len[0]  = heap_len;
        seg_ok[0]   = 1;
        live_allocs = 0;
    endfunction

    function automatic int used_entries();
        int n;
        n = 0;
        while (n < NSEG && seg_ok[n])
            n++;
        return n;
    endfunction

    function automatic void move_entry(input int dst, input int src);
        seg_base[dst] = seg_base[src];
        seg_len[dst]  = seg_len[src];
        seg_busy[dst] = seg_busy[src];
        seg_ok[dst]   = seg_ok[src];
    endfunction

    function automatic void drop_entry(input int k, input int n);
        for (int i = k; i + 1 < n; i++)
            move_entry(i, i + 1);
        seg_base[n-1] = 0;
        seg_len[n-1]  = 0;
        seg_busy[n-1] = 0;
        seg_ok[n-1]   = 0;
    endfunction

    function automatic outcome_t allocate(input logic [FIELD_W-1:0] req);
        outcome_t r;
        int n;
        longint need;
        r = '{addr: '0, st: ST_NO_FIT, live: '0};
        n = used_entries();
        need = ((longint'(req) + HDR + BLK - 1) / BLK) * BLK;
        for (int i = 0; i < n; i++)
        begin
            if (seg_busy[i] || seg_len[i] < need)
                continue;
            if (seg_len[i] - need > HDR)
            begin
                if (n >= NSEG)
                begin
                    r.st = ST_FULL;
                    return r;
                end
                for (int j = n; j > i + 1; j--)
                    move_entry(j, j - 1);
                seg_base[i+1] = seg_base[i] + need;
                seg_len[i+1]  = seg_len[i] - need;
                seg_busy[i+1] = 0;
                seg_ok[i+1]   = 1;
                seg_len[i]    = need;
            end
            seg_busy[i] = 1;
            if (live_allocs < int'(COUNT_MAX))
                live_allocs++;
            r.addr = FIELD_W'(seg_base[i] + HDR);
            r.st   = ST_OK;
            return r;
        end
        return r;
    endfunction

    function automatic status_t release_block(input logic [FIELD_W-1:0] adr);
        int n;
        int k;
        n = used_entries();
        k = -1;
        if (adr < HDR)
            return ST_BAD_OFS;
        for (int i = 0; i < n; i++)
        begin
            if (seg_busy[i] && seg_base[i] == longint'(adr) - HDR)
            begin
                k = i;
                break;
            end
        end
        if (k < 0)
            return ST_BAD_OFS;
        seg_busy[k] = 0;
        if (k + 1 < n && !seg_busy[k+1])
        begin
            seg_len[k] += seg_len[k+1];
            drop_entry(k + 1, n);
            n--;
        end
        if (k > 0 && !seg_busy[k-1])
        begin
            seg_len[k-1] += seg_len[k];
            drop_entry(k, n);
        end
        if (live_allocs > 0)
            live_allocs--;
        return ST_OK;
    endfunction

    function automatic outcome_t apply_request(input logic [IN_W-1:0] d);
        outcome_t r;
        action_t act;
        act = action_t'(d[1:0]);
        r = '{addr: '0, st: ST_OK, live: '0};
        case (act)
            ACT_ALLOC: r = allocate(d[25:2]);
            ACT_FREE:  r.st = release_block(d[49:26]);
            ACT_INIT:  clear_heap();
            default:   r.st = ST_BAD_OFS;
        endcase
        r.live = COUNT_W'(live_allocs);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            heap_len = HEAP_RESET;
            clear_heap();
            outcome_q.delete();
            errors   = 0;
            compared = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                compared++;
                if (outcome_q.size() == 0)
                    report($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tdata[23:0] !== want.addr)
                        report($sformatf("address_out %h, predicted %h",
                                         m_tdata[23:0], want.addr));
                    if (m_tdata[25:24] !== want.st)
                        report($sformatf("status %0d, predicted %s",
                                         m_tdata[25:24], want.st.name()));
                    if (m_tdata[32:26] !== want.live)
                        report($sformatf("live_count %0d, predicted %0d",
                                         m_tdata[32:26], want.live));
                end
            end
            if (s_tvalid && s_tready)
                outcome_q.push_back(apply_request(s_tdata));
            if (cfg_wr_en)
                heap_len = cfg_wr_data;
        end
    end

endmodule

[bench/tb.sv]
// Top of the first-fit heap allocator testbench: clock, reset, stimulus and verdict.
// Depends on ffha_pkg, first_fit_heap_allocator_core and ffha_checker.
`timescale 1ns / 1ps

module tb;
    import ffha_pkg::*;

    localparam longint CYCLE_LIMIT = 1500000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [FIELD_W-1:0] cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    int                 errors;
    int                 pending;
    int                 compared;

    longint             cycles;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_off;
    int                 sent;
    int                 ok_allocs;
    int                 ok_frees;
    int                 full_hits;
    int                 no_fits;
    logic [FIELD_W-1:0] live_addrs[$];

    first_fit_heap_allocator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    ffha_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .pending    (pending),
        .compared   (compared)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            case (status_t'(m_tdata[25:24]))
                ST_OK:     if (m_tdata[23:0] != 0) ok_allocs++;
                ST_NO_FIT: no_fits++;
                ST_FULL:   full_hits++;
                default:   ;
            endcase
            if (m_tdata[25:24] == ST_OK && m_tdata[23:0] != 0)
                live_addrs.push_back(m_tdata[23:0]);
        end
    end

    task automatic send(input action_t act, input logic [FIELD_W-1:0] req,
                        input logic [FIELD_W-1:0] adr);
        bit taken;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, adr, req, act};
        if (act == ACT_INIT)
            live_addrs.delete();
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_heap(input logic [FIELD_W-1:0] len);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        send(ACT_INIT, FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic random_item(input int max_req);
        int roll;
        int pick;
        logic [FIELD_W-1:0] adr;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                send(ACT_ALLOC, FIELD_W'($urandom_range(max_req)), FIELD_W'($urandom));
            else if (pick < 95)
                send(ACT_ALLOC, FIELD_W'($urandom_range(max_req * 40)), FIELD_W'($urandom));
            else
                send(ACT_ALLOC, FIELD_W'($urandom), FIELD_W'($urandom));
        end
        else if (roll < 90 && live_addrs.size() > 0)
        begin
            pick = $urandom_range(live_addrs.size() - 1);
            adr = live_addrs[pick];
            live_addrs.delete(pick);
            ok_frees++;
            send(ACT_FREE, FIELD_W'($urandom), adr);
        end
        else if (roll < 96)
            send(ACT_FREE, FIELD_W'($urandom),
                 FIELD_W'(($urandom_range(1) != 0) ? $urandom : $urandom_range(64)));
        else if (roll < 98)
            send(ACT_INIT, FIELD_W'($urandom), FIELD_W'($urandom));
        else
            send(ACT_NONE, FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    initial
    begin
        cycles        = 0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        hold_off      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent          = 0;
        ok_allocs     = 0;
        ok_frees      = 0;
        full_hits     = 0;
        no_fits       = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ACT_ALLOC, 24'd0, 24'd0);
        send(ACT_ALLOC, 24'hFFFFFF, 24'hFFFFFF);
        send(ACT_ALLOC, 24'd40, 24'd0);
        send(ACT_ALLOC, 24'd41, 24'd0);
        send(ACT_FREE, 24'd0, 24'd0);
        send(ACT_FREE, 24'd0, 24'd23);
        send(ACT_FREE, 24'd0, 24'd25);
        send(ACT_FREE, 24'd0, 24'hFFFFFF);
        send(ACT_FREE, 24'hFFFFFF, 24'd88);
        send(ACT_FREE, 24'd0, 24'd24);
        send(ACT_FREE, 24'd0, 24'd24);
        send(ACT_NONE, 24'hFFFFFF, 24'hFFFFFF);
        send(ACT_ALLOC, 24'hFFFFC0, 24'd0);
        send(ACT_ALLOC, 24'd100, 24'd0);
        send(ACT_INIT, 24'hFFFFFF, 24'hFFFFFF);
        send(ACT_ALLOC, 24'hFFFFE7, 24'd0);

        set_heap(24'd64);
        send(ACT_ALLOC, 24'd40, 24'd0);
        send(ACT_ALLOC, 24'd0, 24'd0);
        send_idle_pct = 26;
        recv_idle_pct = 59;
        repeat (40) random_item(60);

        set_heap(24'd2000);
        repeat (110) random_item(300);

        send_idle_pct = 59;
        recv_idle_pct = 26;
        set_heap(24'd30000);
        repeat (250) random_item(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_heap(24'hFFFFFF);
        repeat (120) random_item(3000);
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (40) random_item(3000);
        join
        repeat (170) random_item(3000);

        settle();
        $display("Ran %0d requests, %0d results compared: %0d allocations, %0d frees,",
                 sent, compared, ok_allocs, ok_frees);
        $display("%0d no-fit and %0d table-full outcomes over heap sizes 64 to 16777215.",
                 no_fits, full_hits);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
